FILE: src/gaa_pkg.sv
// Shared constants and latencies for the gaussian attribute activation core.
package gaa_pkg;

  // Fixed-point constants of the exponential unit
  localparam logic [63:0] LN2_Q56 = 64'h00B1_7217_F7D1_CF7A;
  localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
  localparam int unsigned TAYLOR_TERMS = 25;

  // Field widths
  localparam int unsigned RAW_W   = 24;
  localparam int unsigned ALPHA_W = 17;
  localparam int unsigned SCALE_W = 32;
  localparam int unsigned UNIT_W  = 16;

  // Pipeline depths of each unit, in cycles
  localparam int unsigned EXP_LAT   = 1 + 8 + 1 + 4 * TAYLOR_TERMS;
  localparam int unsigned SCALE_LAT = 1;
  localparam int unsigned ALPHA_LAT = 1 + 17 + 1;
  localparam int unsigned NORM_LAT  = 2 + 3 * 16 + 1;
  localparam int unsigned CORE_LAT  = EXP_LAT + ALPHA_LAT;

  typedef logic [RAW_W-1:0] raw_t;

endpackage

FILE: src/gaa_delay.sv
// Fixed-depth delay line used to line up the result lanes.
module gaa_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  // Shift the item along one tap per cycle
  always_ff @(posedge clk_i) begin
    tap_q[0] <= d_i;
    for (int i = 1; i < DEPTH; i++) begin
      tap_q[i] <= tap_q[i-1];
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

FILE: src/gaa_exp.sv
// Pipelined exponential: range reduction by ln2 and a Taylor series, giving e * 2^k.
module gaa_exp import gaa_pkg::*; (
  input  logic              clk_i,
  input  raw_t              x_i,
  input  logic              inv_i,
  output logic [63:0]       e_o,
  output logic signed [8:0] k_o
);

  logic [23:0] mag;
  logic        neg_in;

  assign mag    = x_i[23] ? (24'd0 - x_i) : x_i;
  assign neg_in = x_i[23] ^ inv_i;

  // Range reduction: restoring division by ln2, one quotient bit a stage
  logic [63:0] drem_q [9];
  logic [7:0]  dquo_q [9];
  logic        dneg_q [9];

  always_ff @(posedge clk_i) begin
    drem_q[0] <= {mag, 40'd0};
    dquo_q[0] <= 8'd0;
    dneg_q[0] <= neg_in;
  end

  for (genvar j = 0; j < 8; j++) begin : g_div
    localparam int B = 7 - j;
    localparam logic [63:0] DSUB = LN2_Q56 << B;
    always_ff @(posedge clk_i) begin
      dneg_q[j+1] <= dneg_q[j];
      if (drem_q[j] >= DSUB) begin
        drem_q[j+1] <= drem_q[j] - DSUB;
        dquo_q[j+1] <= dquo_q[j] | (8'd1 << B);
      end else begin
        drem_q[j+1] <= drem_q[j];
        dquo_q[j+1] <= dquo_q[j];
      end
    end
  end

  // Fold a negative argument into a positive remainder
  logic [8:0]        quo_adj;
  logic [63:0]       rem_adj;
  logic [59:0]       r0_q;
  logic signed [8:0] k0_q;

  always_comb begin
    quo_adj = {1'b0, dquo_q[8]};
    rem_adj = drem_q[8];
    if (dneg_q[8] && (drem_q[8] != 64'd0)) begin
      quo_adj = {1'b0, dquo_q[8]} + 9'd1;
      rem_adj = LN2_Q56 - drem_q[8];
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q <= {rem_adj[55:0], 4'd0};
    k0_q <= dneg_q[8] ? (9'sd0 - $signed(quo_adj)) : $signed(quo_adj);
  end

  // Taylor series, four stages a term: partial products, assemble,
  // reciprocal partial products, then scale and add
  logic [63:0]       tb_term [TAYLOR_TERMS+1];
  logic [63:0]       tb_sum  [TAYLOR_TERMS+1];
  logic [59:0]       tb_r    [TAYLOR_TERMS+1];
  logic signed [8:0] tb_k    [TAYLOR_TERMS+1];

  assign tb_term[0] = ONE_Q60;
  assign tb_sum[0]  = ONE_Q60;
  assign tb_r[0]    = r0_q;
  assign tb_k[0]    = k0_q;

  for (genvar n = 0; n < TAYLOR_TERMS; n++) begin : g_term
    // Divide by n + 1 through its rounded-up reciprocal; exact below 2^60
    localparam int unsigned DIV_SH = 60 + $clog2(n + 1);
    localparam logic [127:0] RECIP_W = ((128'd1 << DIV_SH) + 128'(n)) / 128'(n + 1);
    localparam logic [60:0] RECIP = RECIP_W[60:0];
    logic [63:0]       pp00_q, pp01_q, pp10_q, pp11_q;
    logic [63:0]       qp00_q, qp01_q, qp10_q, qp11_q;
    logic [63:0]       a_sum_q, b_sum_q, c_sum_q, d_term_q, d_sum_q;
    logic [59:0]       a_r_q, b_r_q, c_r_q, d_r_q;
    logic signed [8:0] a_k_q, b_k_q, c_k_q, d_k_q;
    logic [59:0]       b_prod_q;
    logic [127:0]      full;
    logic [127:0]      quo_full;
    logic [63:0]       quo;

    always_ff @(posedge clk_i) begin
      pp00_q  <= 64'(tb_term[n][31:0])  * 64'(tb_r[n][31:0]);
      pp01_q  <= 64'(tb_term[n][31:0])  * 64'(tb_r[n][59:32]);
      pp10_q  <= 64'(tb_term[n][63:32]) * 64'(tb_r[n][31:0]);
      pp11_q  <= 64'(tb_term[n][63:32]) * 64'(tb_r[n][59:32]);
      a_sum_q <= tb_sum[n];
      a_r_q   <= tb_r[n];
      a_k_q   <= tb_k[n];
    end

    assign full = {64'd0, pp00_q} + ({64'd0, pp01_q} << 32) + ({64'd0, pp10_q} << 32)
                + ({64'd0, pp11_q} << 64);

    always_ff @(posedge clk_i) begin
      b_prod_q <= full[119:60];
      b_sum_q  <= a_sum_q;
      b_r_q    <= a_r_q;
      b_k_q    <= a_k_q;
    end

    // Multiply by the reciprocal in 32-bit pieces
    always_ff @(posedge clk_i) begin
      qp00_q  <= 64'(b_prod_q[31:0])  * 64'(RECIP[31:0]);
      qp01_q  <= 64'(b_prod_q[31:0])  * 64'(RECIP[60:32]);
      qp10_q  <= 64'(b_prod_q[59:32]) * 64'(RECIP[31:0]);
      qp11_q  <= 64'(b_prod_q[59:32]) * 64'(RECIP[60:32]);
      c_sum_q <= b_sum_q;
      c_r_q   <= b_r_q;
      c_k_q   <= b_k_q;
    end

    assign quo_full = {64'd0, qp00_q} + ({64'd0, qp01_q} << 32) + ({64'd0, qp10_q} << 32)
                    + ({64'd0, qp11_q} << 64);
    assign quo      = 64'(quo_full >> DIV_SH);

    always_ff @(posedge clk_i) begin
      d_term_q <= quo;
      d_sum_q  <= c_sum_q + quo;
      d_r_q    <= c_r_q;
      d_k_q    <= c_k_q;
    end

    assign tb_term[n+1] = d_term_q;
    assign tb_sum[n+1]  = d_sum_q;
    assign tb_r[n+1]    = d_r_q;
    assign tb_k[n+1]    = d_k_q;
  end

  assign e_o = tb_sum[TAYLOR_TERMS];
  assign k_o = tb_k[TAYLOR_TERMS];

endmodule

FILE: src/gaa_scale_out.sv
// Scale output stage: shift e * 2^k into Q8.24 with rounding and saturation.
module gaa_scale_out import gaa_pkg::*; (
  input  logic               clk_i,
  input  logic [63:0]        e_i,
  input  logic signed [8:0]  k_i,
  output logic [SCALE_W-1:0] scale_o
);

  logic signed [9:0] sh;
  logic [5:0]        sh6;
  logic [63:0]       rounded;

  assign sh      = 10'sd36 - {k_i[8], k_i};
  assign sh6     = sh[5:0];
  assign rounded = (e_i + (64'd1 << (sh6 - 6'd1))) >> sh6;

  // Saturate high, flush low
  always_ff @(posedge clk_i) begin
    if (sh <= 10'sd0) begin
      scale_o <= '1;
    end else if (sh >= 10'sd64) begin
      scale_o <= '0;
    end else if (rounded[63:32] != 32'd0) begin
      scale_o <= '1;
    end else begin
      scale_o <= rounded[31:0];
    end
  end

endmodule

FILE: src/gaa_alpha_out.sv
// Alpha output stage: 2^56 / (2^40 + e * 2^(k-20)) rounded, by a pipelined divider.
module gaa_alpha_out import gaa_pkg::*; (
  input  logic               clk_i,
  input  logic [63:0]        e_i,
  input  logic signed [8:0]  k_i,
  output logic [ALPHA_W-1:0] alpha_o
);

  logic signed [9:0] sh;
  logic [63:0]       shifted;
  logic [63:0]       den;

  assign sh      = 10'sd20 - {k_i[8], k_i};
  assign shifted = (sh >= 10'sd64) ? 64'd0 : (e_i >> sh[5:0]);
  assign den     = (64'd1 << 40) + shifted;

  // Divider stages: one quotient bit each
  logic [63:0]        rem_q [18];
  logic [63:0]        den_q [18];
  logic [ALPHA_W-1:0] quo_q [18];
  logic               zero_q [18];

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= (64'd1 << 56) + (den >> 1);
    den_q[0]  <= den;
    quo_q[0]  <= '0;
    zero_q[0] <= (k_i >= 9'sd20);
  end

  for (genvar j = 0; j < 17; j++) begin : g_div
    localparam int B = 16 - j;
    logic [80:0] dsub;
    assign dsub = {17'd0, den_q[j]} << B;
    always_ff @(posedge clk_i) begin
      den_q[j+1]  <= den_q[j];
      zero_q[j+1] <= zero_q[j];
      if ({17'd0, rem_q[j]} >= dsub) begin
        rem_q[j+1] <= rem_q[j] - dsub[63:0];
        quo_q[j+1] <= quo_q[j] | (ALPHA_W'(1) << B);
      end else begin
        rem_q[j+1] <= rem_q[j];
        quo_q[j+1] <= quo_q[j];
      end
    end
  end

  // Drop to zero when the exponent is out of reach
  always_ff @(posedge clk_i) begin
    alpha_o <= zero_q[17] ? '0 : quo_q[17];
  end

endmodule

FILE: src/gaa_norm.sv
// Quaternion normaliser: sum of squares, then a bitwise search per component.
module gaa_norm import gaa_pkg::*; (
  input  logic                  clk_i,
  input  logic [3:0][RAW_W-1:0] quat_i,
  output logic [3:0][UNIT_W-1:0] unit_o
);

  // Squares of the magnitudes
  logic [3:0][46:0] sq1_q;
  logic [3:0]       neg1_q;

  for (genvar i = 0; i < 4; i++) begin : g_sq
    logic [23:0] mag;
    assign mag = quat_i[i][23] ? (24'd0 - quat_i[i]) : quat_i[i];
    always_ff @(posedge clk_i) begin
      sq1_q[i]  <= 47'(mag) * 47'(mag);
      neg1_q[i] <= quat_i[i][23];
    end
  end

  // Sum of squares
  logic [48:0]      ssum_q;
  logic [3:0][46:0] q2_q;
  logic [3:0]       neg2_q;

  always_ff @(posedge clk_i) begin
    ssum_q <= 49'(sq1_q[0]) + 49'(sq1_q[1]) + 49'(sq1_q[2]) + 49'(sq1_q[3]);
    q2_q   <= sq1_q;
    neg2_q <= neg1_q;
  end

  // Search boundaries between bit steps
  logic [48:0]      sb_s   [17];
  logic [3:0][46:0] sb_q2  [17];
  logic [3:0]       sb_neg [17];
  logic [3:0][15:0] sb_n   [17];

  assign sb_s[0]   = ssum_q;
  assign sb_q2[0]  = q2_q;
  assign sb_neg[0] = neg2_q;
  assign sb_n[0]   = '0;

  for (genvar j = 0; j < 16; j++) begin : g_bit
    localparam int B = 15 - j;
    logic [48:0]      a_s_q, b_s_q, c_s_q;
    logic [3:0][46:0] a_q2_q, b_q2_q, c_q2_q;
    logic [3:0]       a_neg_q, b_neg_q, c_neg_q;
    logic [3:0][15:0] a_n_q, b_n_q, c_n_q;
    logic [3:0][15:0] a_cand_q, b_cand_q;
    logic [3:0][33:0] a_sq_q;
    logic [3:0][57:0] b_plo_q;
    logic [3:0][58:0] b_phi_q;

    for (genvar i = 0; i < 4; i++) begin : g_lane
      logic [15:0] cand;
      logic [16:0] odd;
      logic [82:0] prod;
      logic [82:0] rhs;
      assign cand = sb_n[j][i] | (16'd1 << B);
      assign odd  = {cand, 1'b0} - 17'd1;
      assign prod = {25'd0, b_plo_q[i]} + ({24'd0, b_phi_q[i]} << 24);
      assign rhs  = {4'd0, b_q2_q[i], 32'd0};

      // Try the candidate bit: square, scale by the sum, compare
      always_ff @(posedge clk_i) begin
        a_cand_q[i] <= cand;
        a_sq_q[i]   <= 34'(odd) * 34'(odd);
        b_cand_q[i] <= a_cand_q[i];
        b_plo_q[i]  <= 58'(a_sq_q[i]) * 58'(a_s_q[23:0]);
        b_phi_q[i]  <= 59'(a_sq_q[i]) * 59'(a_s_q[48:24]);
        c_n_q[i]    <= (prod <= rhs) ? b_cand_q[i] : b_n_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      a_s_q   <= sb_s[j];
      a_q2_q  <= sb_q2[j];
      a_neg_q <= sb_neg[j];
      a_n_q   <= sb_n[j];
      b_s_q   <= a_s_q;
      b_q2_q  <= a_q2_q;
      b_neg_q <= a_neg_q;
      b_n_q   <= a_n_q;
      c_s_q   <= b_s_q;
      c_q2_q  <= b_q2_q;
      c_neg_q <= b_neg_q;
    end

    assign sb_s[j+1]   = c_s_q;
    assign sb_q2[j+1]  = c_q2_q;
    assign sb_neg[j+1] = c_neg_q;
    assign sb_n[j+1]   = c_n_q;
  end

  // Apply sign, saturate the positive end, zero for a null quaternion
  for (genvar i = 0; i < 4; i++) begin : g_out
    always_ff @(posedge clk_i) begin
      if (sb_s[16] == 49'd0) begin
        unit_o[i] <= '0;
      end else if (sb_neg[16][i]) begin
        unit_o[i] <= 16'd0 - sb_n[16][i];
      end else if (sb_n[16][i] > 16'd32767) begin
        unit_o[i] <= 16'd32767;
      end else begin
        unit_o[i] <= sb_n[16][i];
      end
    end
  end

endmodule

FILE: src/gaussian_attribute_activation_core.sv
// Top level of the gaussian attribute activation core.
// The delay from start to done_o is set by the exponential unit plus the
// alpha divider; the other lanes are delayed to match.
// Throughput: one item per cycle; busy is always low and results cannot be held off.
// Reset clears only the valid pipeline; payload registers are not reset.
module gaussian_attribute_activation_core import gaa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [RAW_W-1:0]   opacity_logit_i,
  input  logic [RAW_W-1:0]   scale_log_x_i,
  input  logic [RAW_W-1:0]   scale_log_y_i,
  input  logic [RAW_W-1:0]   scale_log_z_i,
  input  logic [RAW_W-1:0]   quat_w_i,
  input  logic [RAW_W-1:0]   quat_x_i,
  input  logic [RAW_W-1:0]   quat_y_i,
  input  logic [RAW_W-1:0]   quat_z_i,
  output logic               done_o,
  output logic [ALPHA_W-1:0] alpha_o,
  output logic [SCALE_W-1:0] scale_x_o,
  output logic [SCALE_W-1:0] scale_y_o,
  output logic [SCALE_W-1:0] scale_z_o,
  output logic [UNIT_W-1:0]  unit_w_o,
  output logic [UNIT_W-1:0]  unit_x_o,
  output logic [UNIT_W-1:0]  unit_y_o,
  output logic [UNIT_W-1:0]  unit_z_o
);

  localparam int unsigned SCALE_PAD = CORE_LAT - EXP_LAT - SCALE_LAT;
  localparam int unsigned NORM_PAD  = CORE_LAT - NORM_LAT;

  assign busy = 1'b0;

  // Carry the valid bit alongside the item
  logic [CORE_LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[CORE_LAT-2:0], start};
    end
  end

  assign done_o = vld_q[CORE_LAT-1];

  // Opacity lane
  logic [63:0]       ae;
  logic signed [8:0] ak;

  gaa_exp u_exp_alpha (
    .clk_i (clk_i),
    .x_i   (opacity_logit_i),
    .inv_i (1'b1),
    .e_o   (ae),
    .k_o   (ak)
  );

  gaa_alpha_out u_alpha (
    .clk_i   (clk_i),
    .e_i     (ae),
    .k_i     (ak),
    .alpha_o (alpha_o)
  );

  // Scale lanes
  raw_t                          scale_raw [3];
  logic [2:0][SCALE_W-1:0]       scale_act;
  logic [2:0][SCALE_W-1:0]       scale_dly;

  assign scale_raw[0] = scale_log_x_i;
  assign scale_raw[1] = scale_log_y_i;
  assign scale_raw[2] = scale_log_z_i;

  for (genvar i = 0; i < 3; i++) begin : g_scale
    logic [63:0]       se;
    logic signed [8:0] sk;

    gaa_exp u_exp (
      .clk_i (clk_i),
      .x_i   (scale_raw[i]),
      .inv_i (1'b0),
      .e_o   (se),
      .k_o   (sk)
    );

    gaa_scale_out u_scale (
      .clk_i   (clk_i),
      .e_i     (se),
      .k_i     (sk),
      .scale_o (scale_act[i])
    );
  end

  gaa_delay #(
    .WIDTH (3 * SCALE_W),
    .DEPTH (SCALE_PAD)
  ) u_scale_dly (
    .clk_i (clk_i),
    .d_i   (scale_act),
    .q_o   (scale_dly)
  );

  assign scale_x_o = scale_dly[0];
  assign scale_y_o = scale_dly[1];
  assign scale_z_o = scale_dly[2];

  // Rotation lane
  logic [3:0][RAW_W-1:0]  quat;
  logic [3:0][UNIT_W-1:0] unit_act;
  logic [3:0][UNIT_W-1:0] unit_dly;

  assign quat = {quat_z_i, quat_y_i, quat_x_i, quat_w_i};

  gaa_norm u_norm (
    .clk_i  (clk_i),
    .quat_i (quat),
    .unit_o (unit_act)
  );

  gaa_delay #(
    .WIDTH (4 * UNIT_W),
    .DEPTH (NORM_PAD)
  ) u_unit_dly (
    .clk_i (clk_i),
    .d_i   (unit_act),
    .q_o   (unit_dly)
  );

  assign unit_w_o = unit_dly[0];
  assign unit_x_o = unit_dly[1];
  assign unit_y_o = unit_dly[2];
  assign unit_z_o = unit_dly[3];

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the gaussian attribute activation core.
`timescale 1ns / 1ps

module tb;
  import gaa_pkg::*;

  localparam int unsigned N_RANDOM  = 1400;
  localparam int unsigned CYC_LIMIT = 200000;
  localparam int unsigned N_ROWS    = 12;

  typedef struct packed {
    raw_t opacity, sx, sy, sz, qw, qx, qy, qz;
  } splat_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [SCALE_W-1:0] sx, sy, sz;
    logic [UNIT_W-1:0]  uw, ux, uy, uz;
  } activ_t;

  typedef struct packed {
    splat_t splat;
    bit     typed;
    activ_t want;
  } row_t;

  logic clk_i, rst_ni, start, busy, done_o;
  splat_t drv;
  activ_t got;
  activ_t drv_want;
  activ_t pending_activations[$];
  int unsigned mismatches, n_items, n_results, n_sat, cycles;

  gaussian_attribute_activation_core dut (
    .clk_i, .rst_ni, .start, .busy,
    .opacity_logit_i(drv.opacity), .scale_log_x_i(drv.sx), .scale_log_y_i(drv.sy),
    .scale_log_z_i(drv.sz), .quat_w_i(drv.qw), .quat_x_i(drv.qx),
    .quat_y_i(drv.qy), .quat_z_i(drv.qz), .done_o,
    .alpha_o(got.alpha), .scale_x_o(got.sx), .scale_y_o(got.sy), .scale_z_o(got.sz),
    .unit_w_o(got.uw), .unit_x_o(got.ux), .unit_y_o(got.uy), .unit_z_o(got.uz)
  );

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // exp(+-mag / 2^16) split into mantissa e in Q.60 and power of two k
  function automatic void exp_split(bit neg, longint unsigned mag,
                                    output longint unsigned e, output int k);
    longint unsigned a, q, rem, r, term, sum;
    bit [127:0] prod;
    a = (mag & 64'hFF_FFFF) << 40;
    q = a / LN2_Q56;
    rem = a - q * LN2_Q56;
    if (neg && rem != 0) begin
      q++;
      rem = LN2_Q56 - rem;
    end
    r = rem << 4;
    term = ONE_Q60;
    sum = ONE_Q60;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      prod = 128'(term) * 128'(r);
      term = 64'(prod >> 60) / longint'(n);
      sum += term;
    end
    e = sum;
    k = neg ? -int'(q) : int'(q);
  endfunction

  function automatic longint signed_raw(raw_t v);
    return longint'($signed(v));
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic logic [SCALE_W-1:0] exp_scale(raw_t raw);
    longint x;
    longint unsigned e, v;
    int k, s;
    x = signed_raw(raw);
    exp_split(x < 0, magnitude(x), e, k);
    s = 36 - k;
    if (s <= 0) return '1;
    if (s >= 64) return '0;
    v = (e + (64'd1 << (s - 1))) >> s;
    return v > 64'hFFFF_FFFF ? '1 : v[31:0];
  endfunction

  function automatic logic [ALPHA_W-1:0] sigmoid_alpha(raw_t raw);
    longint x;
    longint unsigned e, d, res;
    int k, sh;
    x = signed_raw(raw);
    exp_split(!(x < 0), magnitude(x), e, k);
    if (k >= 20) return '0;
    sh = 20 - k;
    d = (64'd1 << 40) + (sh >= 64 ? 64'd0 : (e >> sh));
    res = ((64'd1 << 56) + (d >> 1)) / d;
    return res[ALPHA_W-1:0];
  endfunction

  // true once the normalised magnitude reaches n - 1/2
  function automatic bit reaches_half(longint unsigned n, longint unsigned s,
                                      longint unsigned q2);
    bit [127:0] lhs, rhs;
    lhs = 128'((2 * n - 1) * (2 * n - 1)) * 128'(s);
    rhs = 128'(q2) << 32;
    return lhs <= rhs;
  endfunction

  function automatic logic [UNIT_W-1:0] unit_part(longint q, longint unsigned s);
    longint unsigned m, q2, lo, hi, mid;
    m = magnitude(q);
    q2 = m * m;
    lo = 0;
    hi = 32768;
    if (s == 0) return '0;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (reaches_half(mid, s, q2)) lo = mid;
      else hi = mid - 1;
    end
    if (q < 0) return 16'(17'h10000 - lo);
    return lo > 32767 ? 16'd32767 : lo[15:0];
  endfunction

  function automatic activ_t activate_splat(splat_t sp);
    activ_t a;
    longint q[4];
    longint unsigned s;
    q[0] = signed_raw(sp.qw);
    q[1] = signed_raw(sp.qx);
    q[2] = signed_raw(sp.qy);
    q[3] = signed_raw(sp.qz);
    s = 0;
    for (int i = 0; i < 4; i++) s += magnitude(q[i]) * magnitude(q[i]);
    a.alpha = sigmoid_alpha(sp.opacity);
    a.sx = exp_scale(sp.sx);
    a.sy = exp_scale(sp.sy);
    a.sz = exp_scale(sp.sz);
    a.uw = unit_part(q[0], s);
    a.ux = unit_part(q[1], s);
    a.uy = unit_part(q[2], s);
    a.uz = unit_part(q[3], s);
    return a;
  endfunction

  // Random raw value: full range, moderate, tiny, near the scale limits, extremes
  function automatic raw_t pick_raw(bit for_scale);
    case ($urandom_range(0, 9))
      0, 1:    return raw_t'($urandom);
      2, 3, 4: return raw_t'($urandom_range(0, 2 * 1048576) - 1048576);
      5:       return raw_t'($urandom_range(0, 512) - 256);
      6:       return for_scale ? raw_t'($urandom_range(1400000, 1500000))
                                : raw_t'($urandom_range(0, 65536));
      7:       return for_scale ? raw_t'(-int'($urandom_range(1100000, 1180000)))
                                : raw_t'(-int'($urandom_range(0, 65536)));
      8:       return $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
      default: return raw_t'($urandom_range(0, 8 * 65536) - 4 * 65536);
    endcase
  endfunction

  function automatic splat_t random_splat();
    splat_t sp;
    sp.opacity = pick_raw(1'b0);
    sp.sx = pick_raw(1'b1);
    sp.sy = pick_raw(1'b1);
    sp.sz = pick_raw(1'b1);
    sp.qw = pick_raw(1'b0);
    sp.qx = pick_raw(1'b0);
    sp.qy = pick_raw(1'b0);
    sp.qz = pick_raw(1'b0);
    if ($urandom_range(0, 31) == 0) {sp.qw, sp.qx, sp.qy, sp.qz} = '0;
    return sp;
  endfunction

  // Directed rows: all-zero, extremes, zero quaternion, saturating unit components
  row_t rows[N_ROWS];
  initial begin
    rows[0]  = '{'{24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0}, 1'b1,
                 '{17'd32768, 32'd16777216, 32'd16777216, 32'd16777216,
                   16'd0, 16'd0, 16'd0, 16'd0}};
    rows[1]  = '{'{24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF,
                   24'h01_0000, 24'h0, 24'h0, 24'h0}, 1'b1,
                 '{17'd65536, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   16'd32767, 16'd0, 16'd0, 16'd0}};
    rows[2]  = '{'{24'h80_0000, 24'h80_0000, 24'h80_0000, 24'h80_0000,
                   24'hFF_0000, 24'h0, 24'h0, 24'h0}, 1'b1,
                 '{17'd0, 32'd0, 32'd0, 32'd0, 16'h8000, 16'd0, 16'd0, 16'd0}};
    rows[3]  = '{'{24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h7F_FFFF, 24'h0, 24'h0}, 1'b1,
                 '{17'd32768, 32'd16777216, 32'd16777216, 32'd16777216,
                   16'd0, 16'd32767, 16'd0, 16'd0}};
    rows[4]  = '{'{24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h80_0000, 24'h0}, 1'b1,
                 '{17'd32768, 32'd16777216, 32'd16777216, 32'd16777216,
                   16'd0, 16'd0, 16'h8000, 16'd0}};
    rows[5]  = '{'{24'h01_0000, 24'h01_0000, 24'hFF_0000, 24'h16_2E42,
                   24'h01_0000, 24'h01_0000, 24'h01_0000, 24'h01_0000}, 1'b0, '0};
    rows[6]  = '{'{24'hFF_FFFF, 24'h00_0001, 24'hFF_FFFF, 24'h16_3000,
                   24'h00_0001, 24'hFF_FFFF, 24'h00_0001, 24'hFF_FFFF}, 1'b0, '0};
    rows[7]  = '{'{24'h14_0000, 24'hEE_0000, 24'hEF_0000, 24'h16_2000,
                   24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF, 24'h80_0000}, 1'b0, '0};
    rows[8]  = '{'{24'hEC_0000, 24'h00_B172, 24'hFF_4E8E, 24'h00_0000,
                   24'h00_0003, 24'h00_0004, 24'h00_0000, 24'h00_0000}, 1'b0, '0};
    rows[9]  = '{'{24'h0D_0000, 24'h15_0000, 24'hF0_0000, 24'h10_0000,
                   24'h00_0001, 24'h00_0001, 24'h00_0001, 24'h00_0000}, 1'b0, '0};
    rows[10] = '{'{24'hF3_0000, 24'h55_5555, 24'hAA_AAAA, 24'h12_3456,
                   24'h55_5555, 24'hAA_AAAA, 24'h12_3456, 24'hED_CBA9}, 1'b0, '0};
    rows[11] = '{'{24'h00_8000, 24'hFF_8000, 24'h00_0000, 24'h00_0000,
                   24'h00_0000, 24'h00_0000, 24'h00_0000, 24'h00_0000}, 1'b0, '0};
  end

  // Drive one item at the falling edge and hold it until accepted
  task automatic send_splat(splat_t sp, activ_t want);
    @(negedge clk_i);
    drv = sp;
    drv_want = want;
    start = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic idle_for(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start = 1'b0;
      drv = splat_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    end
  endtask

  task automatic drain();
    while (pending_activations.size() != 0) @(posedge clk_i);
  endtask

  // Accept items and check results at the rising edge
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else if (rst_ni) begin
      if (done_o) begin
        n_results++;
        if (pending_activations.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result with nothing outstanding: %h", got);
        end else begin
          activ_t exp_a;
          exp_a = pending_activations.pop_front();
          if (got !== exp_a) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch\n  want a=%h sx=%h sy=%h sz=%h q=%h %h %h %h",
                       exp_a.alpha, exp_a.sx, exp_a.sy, exp_a.sz,
                       exp_a.uw, exp_a.ux, exp_a.uy, exp_a.uz);
              $display("  got  a=%h sx=%h sy=%h sz=%h q=%h %h %h %h",
                       got.alpha, got.sx, got.sy, got.sz,
                       got.uw, got.ux, got.uy, got.uz);
            end
          end
        end
      end
      if (start && !busy) begin
        pending_activations = {pending_activations, drv_want};
        n_items++;
        if (drv_want.sx == '1 || drv_want.sy == '1 || drv_want.sz == '1) n_sat++;
      end
    end
  end

  initial begin
    splat_t sp;
    int unsigned sent, burst;
    cycles = 0;
    mismatches = 0;
    n_items = 0;
    n_results = 0;
    n_sat = 0;
    start = 1'b0;
    drv = '0;
    drv_want = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows, typed expectation where given
    foreach (rows[i]) begin
      send_splat(rows[i].splat,
                 rows[i].typed ? rows[i].want : activate_splat(rows[i].splat));
      if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 4));
    end

    // Hold off until the pipe is empty once
    idle_for(1);
    drain();

    // Random bursts with random gaps
    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        sp = random_splat();
        send_splat(sp, activate_splat(sp));
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 12));
      if (sent > N_RANDOM / 2 && sent < N_RANDOM / 2 + 41) begin
        idle_for(1);
        drain();
      end
    end
    idle_for(1);

    // Drain, then let the pipe run dry
    drain();
    repeat (CORE_LAT + 20) @(posedge clk_i);
    if (pending_activations.size() != 0 || n_results != n_items) mismatches++;
    $display("items %0d, results %0d, items with a saturated scale %0d, mismatches %0d",
             n_items, n_results, n_sat, mismatches);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/gaa_pkg.sv
src/gaa_delay.sv
src/gaa_exp.sv
src/gaa_scale_out.sv
src/gaa_alpha_out.sv
src/gaa_norm.sv
src/gaussian_attribute_activation_core.sv
tb/sv/tb.sv
